/* design/rgb_to_hsv_converter_unit_macros.svh */
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Concurrent check wrappers shared by the converter files.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

// check a same-cycle implication
`define RHSV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsv_converter_unit: check failed");

// check an implication a fixed number of cycles ahead
`define RHSV_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("rgb_to_hsv_converter_unit: delayed check failed");

`endif

/* design/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, hue constants, sector codes and pipeline sizing.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam logic [CHANNEL_BITS-1:0] CHANNEL_FULL = '1;

   localparam int HUE_BITS = 15;
   localparam int HUE_TERM_BITS = 12;
   localparam logic [HUE_BITS-1:0] HUE_SIXTY = 15'd3840;
   localparam logic [HUE_BITS-1:0] HUE_RED_BASE = 15'd0;
   localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = 15'd7680;
   localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE = 15'd15360;
   localparam logic [HUE_BITS-1:0] HUE_CIRCLE = 15'd23040;

   // divider sizing: quotient never exceeds FULL or 3840
   localparam int DIV_QUO_W = (CHANNEL_BITS > HUE_TERM_BITS) ? CHANNEL_BITS : HUE_TERM_BITS;
   localparam int DIV_NUM_W = CHANNEL_BITS + DIV_QUO_W;
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = (DIV_QUO_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LATENCY = DIV_STAGES + 3;

   localparam logic [1:0] SEL_RED = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE = 2'd2;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] mx;
      logic [1:0]              sel;
      logic                    neg;
      logic                    zero;
   } side_type;

endpackage

/* design/rgbhsv_div.sv */
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring unsigned division, two quotient bits per register stage.
// ----------------------------------------------------------------------------
module rgbhsv_div
   import rgbhsv_pkg::*;
(
   input  logic                    clock,
   input  logic [DIV_NUM_W-1:0]    in_num,
   input  logic [CHANNEL_BITS-1:0] in_den,
   output logic [DIV_QUO_W-1:0]    out_quo
);

   logic [CHANNEL_BITS-1:0] rem_ff [DIV_STAGES-1];
   logic [CHANNEL_BITS-1:0] den_ff [DIV_STAGES-1];
   logic [DIV_QUO_W-1:0]    rq_ff  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [CHANNEL_BITS-1:0] rem_src;
      logic [CHANNEL_BITS-1:0] den_src;
      logic [DIV_QUO_W-1:0]    rq_src;
      logic [CHANNEL_BITS-1:0] rem_in;
      logic [DIV_QUO_W-1:0]    rq_in;

      if (s == 0) begin : g_first
         assign rem_src = in_num[DIV_NUM_W-1:DIV_QUO_W];
         assign rq_src  = in_num[DIV_QUO_W-1:0];
         assign den_src = in_den;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign rq_src  = rq_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      always_comb begin
         logic [CHANNEL_BITS:0] trial;
         rem_in = rem_src;
         rq_in  = rq_src;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (s * DIV_STEPS + j < DIV_QUO_W) begin
               trial = {rem_in, rq_in[DIV_QUO_W-1]};
               rq_in = {rq_in[DIV_QUO_W-2:0], 1'b0};
               if (trial >= {1'b0, den_src}) begin
                  rem_in   = CHANNEL_BITS'(trial - {1'b0, den_src});
                  rq_in[0] = 1'b1;
               end else begin
                  rem_in = trial[CHANNEL_BITS-1:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         rq_ff[s] <= rq_in;
      end

      if (s < DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
         end
      end
   end

   assign out_quo = rq_ff[DIV_STAGES-1];

endmodule

/* design/rgb_to_hsv_converter_unit.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter unit
// Converts one pixel of three unsigned channels into hue, saturation, value.
//
// Input: a pixel on req_red, req_green, req_blue transfers at a rising edge
// with start high and busy low. busy is high only while reset is applied, so
// outside reset a new pixel can transfer in every cycle.
// Output: each result sits on rsp_hue, rsp_saturation and rsp_value for one
// cycle, marked by rsp_strobe, in transfer order. The receiver takes every
// result; there is no back pressure.
// Hue is degrees times 64 (0 to 23039), saturation is FULL*(max-min)/max,
// value is the largest channel. Black and grey pixels give hue 0 and
// saturation 0.
// Throughput: one pixel per cycle outside reset. Each pixel passes stage 1,
// stage 2, the DIV_STAGES divider stages and the output register in turn;
// the two restoring dividers, at two quotient bits per stage, set DIV_STAGES.
// Reset: synchronous, clears all valid bits; no result is left in flight.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit
   import rgbhsv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CHANNEL_BITS-1:0] req_red,
   input  logic [CHANNEL_BITS-1:0] req_green,
   input  logic [CHANNEL_BITS-1:0] req_blue,
   output logic                    rsp_strobe,
   output logic [HUE_BITS-1:0]     rsp_hue,
   output logic [CHANNEL_BITS-1:0] rsp_saturation,
   output logic [CHANNEL_BITS-1:0] rsp_value
);

   logic                    transfer;

   logic [CHANNEL_BITS-1:0] s1_mx_in, s1_mn_in, s1_p_in, s1_m_in;
   logic [1:0]              s1_sel_in;
   logic                    s1_valid_ff;
   logic [CHANNEL_BITS-1:0] s1_mx_ff, s1_mn_ff, s1_p_ff, s1_m_ff;
   logic [1:0]              s1_sel_ff;

   logic [CHANNEL_BITS-1:0] s2_delta_in, s2_mag_in;
   side_type                s2_side_in;
   logic [DIV_NUM_W-1:0]    s2_sat_num_in, s2_hue_num_in;
   logic                    s2_valid_ff;
   side_type                s2_side_ff;
   logic [CHANNEL_BITS-1:0] s2_delta_ff;
   logic [DIV_NUM_W-1:0]    s2_sat_num_ff, s2_hue_num_ff;

   logic                    dv_valid_ff [DIV_STAGES];
   side_type                dv_side_ff  [DIV_STAGES];
   logic [DIV_QUO_W-1:0]    sat_quo, hue_quo;

   side_type                fin_side;
   logic [HUE_BITS-1:0]     hue_base;
   logic [HUE_BITS:0]       hue_term, hue_sum;
   logic [HUE_BITS-1:0]     rsp_hue_in;
   logic [CHANNEL_BITS-1:0] rsp_sat_in;

   logic                    rsp_strobe_ff;
   logic [HUE_BITS-1:0]     rsp_hue_ff;
   logic [CHANNEL_BITS-1:0] rsp_sat_ff, rsp_value_ff;

   assign busy     = reset;
   assign transfer = start && !busy;

   // stage 1: largest channel, sector and difference operands
   always_comb begin
      priority if (req_red >= req_green && req_red >= req_blue) begin
         s1_sel_in = SEL_RED;
         s1_mx_in  = req_red;
         s1_p_in   = req_green;
         s1_m_in   = req_blue;
      end else if (req_green >= req_blue) begin
         s1_sel_in = SEL_GREEN;
         s1_mx_in  = req_green;
         s1_p_in   = req_blue;
         s1_m_in   = req_red;
      end else begin
         s1_sel_in = SEL_BLUE;
         s1_mx_in  = req_blue;
         s1_p_in   = req_red;
         s1_m_in   = req_green;
      end
      s1_mn_in = (req_red <= req_green) ? req_red : req_green;
      if (req_blue < s1_mn_in) begin
         s1_mn_in = req_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= transfer;
      end
      s1_mx_ff  <= s1_mx_in;
      s1_mn_ff  <= s1_mn_in;
      s1_p_ff   <= s1_p_in;
      s1_m_ff   <= s1_m_in;
      s1_sel_ff <= s1_sel_in;
   end

   // stage 2: delta, difference magnitude, scaled numerators
   always_comb begin
      s2_delta_in     = s1_mx_ff - s1_mn_ff;
      s2_side_in.mx   = s1_mx_ff;
      s2_side_in.sel  = s1_sel_ff;
      s2_side_in.neg  = s1_p_ff < s1_m_ff;
      s2_side_in.zero = s2_delta_in == '0;
      s2_mag_in       = s2_side_in.neg ? (s1_m_ff - s1_p_ff) : (s1_p_ff - s1_m_ff);
      s2_sat_num_in   = DIV_NUM_W'(s2_delta_in) * DIV_NUM_W'(CHANNEL_FULL);
      s2_hue_num_in   = DIV_NUM_W'(s2_mag_in) * DIV_NUM_W'(HUE_SIXTY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_side_ff    <= s2_side_in;
      s2_delta_ff   <= s2_delta_in;
      s2_sat_num_ff <= s2_sat_num_in;
      s2_hue_num_ff <= s2_hue_num_in;
   end

   // divider stages
   rgbhsv_div u_sat_div (
      .clock   (clock),
      .in_num  (s2_sat_num_ff),
      .in_den  (s2_side_ff.mx),
      .out_quo (sat_quo)
   );

   rgbhsv_div u_hue_div (
      .clock   (clock),
      .in_num  (s2_hue_num_ff),
      .in_den  (s2_delta_ff),
      .out_quo (hue_quo)
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[s] <= 1'b0;
            end else begin
               dv_valid_ff[s] <= s2_valid_ff;
            end
            dv_side_ff[s] <= s2_side_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[s] <= 1'b0;
            end else begin
               dv_valid_ff[s] <= dv_valid_ff[s-1];
            end
            dv_side_ff[s] <= dv_side_ff[s-1];
         end
      end
   end

   // final stage: sector offset, sign, wrap, grey and black override
   always_comb begin
      fin_side = dv_side_ff[DIV_STAGES-1];
      unique case (fin_side.sel)
         SEL_RED:   hue_base = HUE_RED_BASE;
         SEL_GREEN: hue_base = HUE_GREEN_BASE;
         default:   hue_base = HUE_BLUE_BASE;
      endcase
      hue_term = (HUE_BITS+1)'(hue_quo[HUE_TERM_BITS-1:0]);
      hue_sum  = fin_side.neg ? ({1'b0, hue_base} - hue_term) : ({1'b0, hue_base} + hue_term);
      if (hue_sum[HUE_BITS]) begin
         hue_sum = hue_sum + {1'b0, HUE_CIRCLE};
      end
      if (fin_side.zero) begin
         rsp_hue_in = '0;
         rsp_sat_in = '0;
      end else begin
         rsp_hue_in = hue_sum[HUE_BITS-1:0];
         rsp_sat_in = sat_quo[CHANNEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid_ff[DIV_STAGES-1];
      end
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_value_ff <= fin_side.mx;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_value      = rsp_value_ff;

   `RHSV_ASSERT_DELAY(a_result_follows, clock, reset, transfer, LATENCY, rsp_strobe)
   `RHSV_ASSERT_IMPLY(a_result_has_source, clock, reset, rsp_strobe, $past(transfer, LATENCY))
   `RHSV_ASSERT_IMPLY(a_black_is_zero, clock, reset, rsp_strobe && rsp_value == '0, rsp_hue == '0 && rsp_saturation == '0)

endmodule
